// File: hdl/lzb_pkg.sv
package lzb_pkg;

  localparam int WINDOW_BYTES = 131072;
  localparam int WIN_AW       = $clog2(WINDOW_BYTES);
  localparam int DIST_W       = 17;
  localparam int SIZE_W       = 24;
  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int OCC_W        = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_DONE     = 2'd1,
    ST_BADREF   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic              emit;
    logic              copy;
    logic              taken;
    logic [7:0]        lit;
    logic [WIN_AW-1:0] rd_addr;
    logic [WIN_AW-1:0] wr_addr;
    status_t           status;
    logic [SIZE_W-1:0] size;
  } step_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              out_valid;
    logic              byte_taken;
    status_t           status;
    logic [SIZE_W-1:0] declared_size;
  } res_t;

endpackage

// File: hdl/lzb_in_if.sv
interface lzb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_valid;

  modport source (output valid, output in_byte, output in_valid, input ready);
  modport sink   (input valid, input in_byte, input in_valid, output ready);
endinterface

// File: hdl/lzb_out_if.sv
interface lzb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        byte_taken;
  logic [1:0]  status;
  logic [23:0] declared_size;

  modport source (output valid, output out_byte, output out_valid, output byte_taken,
                  output status, output declared_size, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input byte_taken,
                  input status, input declared_size, output ready);
endinterface

// File: hdl/lzb_ctrl.sv
module lzb_ctrl import lzb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lzb_in_if.sink            in_ch,
  input  logic [OCC_W-1:0]  occ,
  output logic              rd_en,
  output logic [WIN_AW-1:0] rd_addr,
  output logic              step_v,
  output step_t             step
);

  typedef enum logic [2:0] {
    PH_SIG, PH_SKIP, PH_SIZE, PH_CMD, PH_LIT, PH_COPY, PH_HALT
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        hc_r, hc_nxt;
  logic              packed_r, packed_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] prod_r, prod_nxt;
  logic [7:0]        cmd_r [4];
  logic [7:0]        cmd_nxt [4];
  logic [1:0]        idx_r, idx_nxt;
  logic [6:0]        lit_left_r, lit_left_nxt;
  logic [10:0]       copy_left_r, copy_left_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [WIN_AW-1:0] wpos_r, wpos_nxt;
  status_t           status_r, status_nxt;
  logic              stop_r, stop_nxt;
  logic              s1_v_r;
  step_t             s1_r;

  logic              in_fire;
  logic              emit, copy, taken, overflow;
  logic [7:0]        b0, b1, b2, b3;
  logic [2:0]        cmd_len;
  logic              cmd_done;
  logic [6:0]        dec_lit;
  logic [DIST_W-1:0] dec_dist;
  logic [10:0]       dec_copy;
  logic              dec_stop;
  logic              dec_has_dist;
  logic              al_stop;
  logic [10:0]       al_copy;
  logic [DIST_W-1:0] al_dist;
  logic [SIZE_W-1:0] al_prod;
  phase_t            al_phase;
  status_t           al_status;

  assign in_ch.ready = (occ + {{(OCC_W-1){1'b0}}, s1_v_r}) < OCC_W'(OUTQ_DEPTH);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign overflow    = prod_r >= size_r;

  assign b0 = (idx_r == 2'd0) ? in_ch.in_byte : cmd_r[0];
  assign b1 = (idx_r == 2'd1) ? in_ch.in_byte : cmd_r[1];
  assign b2 = (idx_r == 2'd2) ? in_ch.in_byte : cmd_r[2];
  assign b3 = (idx_r == 2'd3) ? in_ch.in_byte : cmd_r[3];

  always_comb begin
    dec_has_dist = 1'b1;
    dec_stop     = 1'b0;
    dec_dist     = dist_r;
    if (!b0[7]) begin
      cmd_len  = 3'd2;
      dec_lit  = {5'd0, b0[1:0]};
      dec_dist = {7'd0, b0[6:5], b1};
      dec_copy = {8'd0, b0[4:2]} + 11'd3;
    end else if (!b0[6]) begin
      cmd_len  = 3'd3;
      dec_lit  = {5'd0, b1[7:6]};
      dec_dist = {3'd0, b1[5:0], b2};
      dec_copy = {5'd0, b0[5:0]} + 11'd4;
    end else if (!b0[5]) begin
      cmd_len  = 3'd4;
      dec_lit  = {5'd0, b0[1:0]};
      dec_dist = {b0[4], b1, b2};
      dec_copy = {1'b0, b0[3:2], b3} + 11'd5;
    end else begin
      cmd_len      = 3'd1;
      dec_has_dist = 1'b0;
      dec_copy     = 11'd0;
      if (b0[4:0] <= 5'd27) begin
        dec_lit = {b0[4:0], 2'b00} + 7'd4;
      end else begin
        dec_lit  = {5'd0, b0[1:0]};
        dec_stop = 1'b1;
      end
    end
    cmd_done = ({1'b0, idx_r} + 3'd1) >= cmd_len;
  end

  always_comb begin
    if (phase_r == PH_CMD) begin
      al_stop = dec_stop;
      al_copy = dec_copy;
      al_dist = dec_has_dist ? dec_dist : dist_r;
      al_prod = prod_r;
    end else begin
      al_stop = stop_r;
      al_copy = copy_left_r;
      al_dist = dist_r;
      al_prod = prod_r + SIZE_W'(1);
    end
  end

  always_comb begin
    al_status = status_r;
    if (al_stop) begin
      al_phase  = PH_HALT;
      al_status = ST_DONE;
    end else if (al_copy == 11'd0) begin
      al_phase = PH_CMD;
    end else if (SIZE_W'(al_dist) >= al_prod) begin
      al_phase  = PH_HALT;
      al_status = ST_BADREF;
    end else begin
      al_phase = PH_COPY;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    hc_nxt        = hc_r;
    packed_nxt    = packed_r;
    size_nxt      = size_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    lit_left_nxt  = lit_left_r;
    copy_left_nxt = copy_left_r;
    dist_nxt      = dist_r;
    status_nxt    = status_r;
    stop_nxt      = stop_r;
    emit          = 1'b0;
    copy          = 1'b0;
    taken         = 1'b0;
    case (phase_r)
      PH_COPY: begin
        if (overflow) begin
          phase_nxt  = PH_HALT;
          status_nxt = ST_OVERFLOW;
        end else begin
          emit          = 1'b1;
          copy          = 1'b1;
          copy_left_nxt = copy_left_r - 11'd1;
          if (copy_left_r == 11'd1) begin
            phase_nxt = PH_CMD;
          end
        end
      end
      PH_HALT: begin
      end
      default: begin
        if (in_ch.in_valid) begin
          case (phase_r)
            PH_SIG: begin
              taken = 1'b1;
              if (hc_r == 2'd0) begin
                packed_nxt = in_ch.in_byte[0];
                hc_nxt     = 2'd1;
              end else begin
                hc_nxt    = 2'd0;
                phase_nxt = packed_r ? PH_SKIP : PH_SIZE;
              end
            end
            PH_SKIP: begin
              taken = 1'b1;
              if (hc_r == 2'd2) begin
                hc_nxt    = 2'd0;
                phase_nxt = PH_SIZE;
              end else begin
                hc_nxt = hc_r + 2'd1;
              end
            end
            PH_SIZE: begin
              taken    = 1'b1;
              size_nxt = {size_r[SIZE_W-9:0], in_ch.in_byte};
              if (hc_r == 2'd2) begin
                hc_nxt    = 2'd0;
                phase_nxt = PH_CMD;
              end else begin
                hc_nxt = hc_r + 2'd1;
              end
            end
            PH_CMD: begin
              taken          = 1'b1;
              cmd_nxt[idx_r] = in_ch.in_byte;
              if (cmd_done) begin
                idx_nxt       = 2'd0;
                lit_left_nxt  = dec_lit;
                copy_left_nxt = dec_copy;
                dist_nxt      = al_dist;
                stop_nxt      = dec_stop;
                if (dec_lit != 7'd0) begin
                  phase_nxt = PH_LIT;
                end else begin
                  phase_nxt  = al_phase;
                  status_nxt = al_status;
                end
              end else begin
                idx_nxt = idx_r + 2'd1;
              end
            end
            PH_LIT: begin
              if (overflow) begin
                phase_nxt  = PH_HALT;
                status_nxt = ST_OVERFLOW;
              end else begin
                taken        = 1'b1;
                emit         = 1'b1;
                lit_left_nxt = lit_left_r - 7'd1;
                if (lit_left_r == 7'd1) begin
                  phase_nxt  = al_phase;
                  status_nxt = al_status;
                end
              end
            end
            default: begin
              phase_nxt = PH_HALT;
            end
          endcase
        end
      end
    endcase
    wpos_nxt = emit ? wpos_r + WIN_AW'(1) : wpos_r;
    prod_nxt = emit ? prod_r + SIZE_W'(1) : prod_r;
  end

  assign rd_en   = in_fire && copy;
  assign rd_addr = wpos_r - dist_r[WIN_AW-1:0] - WIN_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      hc_r        <= 2'd0;
      packed_r    <= 1'b0;
      size_r      <= '0;
      prod_r      <= '0;
      cmd_r       <= '{default: 8'd0};
      idx_r       <= 2'd0;
      lit_left_r  <= 7'd0;
      copy_left_r <= 11'd0;
      dist_r      <= '0;
      wpos_r      <= '0;
      status_r    <= ST_RUN;
      stop_r      <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      if (in_fire) begin
        phase_r     <= phase_nxt;
        hc_r        <= hc_nxt;
        packed_r    <= packed_nxt;
        size_r      <= size_nxt;
        prod_r      <= prod_nxt;
        cmd_r       <= cmd_nxt;
        idx_r       <= idx_nxt;
        lit_left_r  <= lit_left_nxt;
        copy_left_r <= copy_left_nxt;
        dist_r      <= dist_nxt;
        wpos_r      <= wpos_nxt;
        status_r    <= status_nxt;
        stop_r      <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.emit    <= emit;
      s1_r.copy    <= copy;
      s1_r.taken   <= taken;
      s1_r.lit     <= in_ch.in_byte;
      s1_r.rd_addr <= rd_addr;
      s1_r.wr_addr <= wpos_r;
      s1_r.status  <= status_nxt;
      s1_r.size    <= size_nxt;
    end
  end

  assign step_v = s1_v_r;
  assign step   = s1_r;

`ifndef NO_ASSERTIONS
  a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COPY |-> copy_left_r != 11'd0)
    else $error("copy phase with nothing left to copy");
  a_copy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_COPY |=> s1_r.emit || s1_r.status == ST_OVERFLOW)
    else $error("copy step neither emitted nor flagged overflow");
`endif

endmodule

// File: hdl/lzb_hist.sv
module lzb_hist import lzb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [WIN_AW-1:0] rd_addr,
  input  logic              step_v,
  input  step_t             step,
  output logic              res_v,
  output res_t              res
);

  logic [7:0]        mem [WINDOW_BYTES];
  logic [7:0]        rdata_r;
  logic              last_wv_r;
  logic [WIN_AW-1:0] last_wa_r;
  logic [7:0]        last_wd_r;

  logic              we;
  logic              fwd_hit;
  logic [7:0]        wd;

  assign we      = step_v && step.emit;
  assign fwd_hit = last_wv_r && (last_wa_r == step.rd_addr);
  assign wd      = step.copy ? (fwd_hit ? last_wd_r : rdata_r) : step.lit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[step.wr_addr] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wv_r <= 1'b0;
    end else begin
      last_wv_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    last_wa_r <= step.wr_addr;
    last_wd_r <= wd;
  end

  assign res_v             = step_v;
  assign res.out_byte      = step.emit ? wd : 8'd0;
  assign res.out_valid     = step.emit;
  assign res.byte_taken    = step.taken;
  assign res.status        = step.status;
  assign res.declared_size = step.size;

`ifndef NO_ASSERTIONS
  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    step_v && step.copy |-> $past(rd_en))
    else $error("copy step without a history read one cycle earlier");
`endif

endmodule

// File: hdl/lzb_outq.sv
module lzb_outq import lzb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  res_t             push_res,
  output logic [OCC_W-1:0] occ,
  lzb_out_if.source        out_ch
);

  res_t               q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wp_r, rp_r;
  logic [OCC_W-1:0]   cnt_r;
  logic               pop;
  res_t               head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = q_r[rp_r];
  assign occ  = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + OUTQ_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + OUTQ_AW'(1);
      end
      cnt_r <= cnt_r + OCC_W'(push) - OCC_W'(pop);
    end
  end

  assign out_ch.valid         = cnt_r != '0;
  assign out_ch.out_byte      = head.out_byte;
  assign out_ch.out_valid     = head.out_valid;
  assign out_ch.byte_taken    = head.byte_taken;
  assign out_ch.status        = head.status;
  assign out_ch.declared_size = head.declared_size;

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < OCC_W'(OUTQ_DEPTH))
    else $error("result queue overrun");
`endif

endmodule

// File: hdl/lz_backref_stream_decompressor.sv
// Path: a transaction accepted on in_ch is registered in the control step register,
// passes through the history stage and is pushed into the result queue for out_ch.
// Throughput: one transaction per cycle while the result queue has room; the step
// state loop and one history read plus one history write per cycle set that figure.
// Back-references of distance one are served by a write-forwarding register.
// Reset: synchronous, active low; clears control state and the result queue.
// The history memory is not cleared and needs no clearing pass.
module lz_backref_stream_decompressor import lzb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lzb_in_if.sink    in_ch,
  lzb_out_if.source out_ch
);

  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;
  logic              step_v;
  step_t             step;
  logic              res_v;
  res_t              res;
  logic [OCC_W-1:0]  occ;

  lzb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .occ     (occ),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .step_v  (step_v),
    .step    (step)
  );

  lzb_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .step_v  (step_v),
    .step    (step),
    .res_v   (res_v),
    .res     (res)
  );

  lzb_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_v),
    .push_res (res),
    .occ      (occ),
    .out_ch   (out_ch)
  );

endmodule

// File: tb/lz_backref_stream_decompressor_test.sv
module lz_backref_stream_decompressor_test;
  import lzb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          NUM_DIR     = 22;
  localparam logic [23:0] DECL_SIZE   = 24'h000384;
  localparam int unsigned DIST_CAP [3] = '{1023, 16383, 131071};
  localparam int unsigned LEN_LO [3]   = '{3, 4, 5};
  localparam int unsigned LEN_HI [3]   = '{10, 67, 1028};

  typedef enum logic [2:0] {
    DP_SIG, DP_SKIP, DP_SIZE, DP_CMD, DP_LIT, DP_COPY, DP_HALT
  } dec_phase_e;

  typedef enum logic [1:0] {CK_TWO, CK_THREE, CK_FOUR, CK_RUN} cmd_kind_e;
  typedef enum logic [1:0] {END_STOP, END_BADREF, END_OVER_LIT, END_OVER_COPY} end_kind_e;

  typedef struct {
    logic [7:0] b;
    logic       v;
    bit         known;
    res_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle = 1'b0;
  int   mismatches = 0;
  int   cycle_cnt = 0;

  res_t       predicted_steps [$];
  logic [7:0] packed_stream [$];

  logic [7:0]        hist_mem [WINDOW_BYTES];
  dec_phase_e        dph = DP_SIG;
  status_t           stat = ST_RUN;
  int unsigned       hdr_cnt = 0;
  int unsigned       cmd_idx = 0;
  int unsigned       lits_left = 0;
  int unsigned       copy_left = 0;
  int unsigned       copy_dist = 0;
  int unsigned       produced = 0;
  int unsigned       decl_size = 0;
  int unsigned       plan_out = 0;
  logic              packed_size_flag = 1'b0;
  logic              stop_seen = 1'b0;
  logic [WIN_AW-1:0] wr_pos = '0;
  logic [7:0]        cmd_buf [4] = '{8'h00, 8'h00, 8'h00, 8'h00};

  dir_row_t dir_rows [NUM_DIR] = '{
    '{8'hFF, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, ST_RUN, 24'h000000}},
    '{8'h11, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000000}},
    '{8'hFB, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000000}},
    '{8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, ST_RUN, 24'h000000}},
    '{8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000000}},
    '{8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000000}},
    '{8'h5A, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000000}},
    '{8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000000}},
    '{8'h03, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, 24'h000003}},
    '{8'h84, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, ST_RUN, DECL_SIZE}},
    '{8'hE0, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, ST_RUN, DECL_SIZE}},
    '{8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1, ST_RUN, DECL_SIZE}},
    '{8'hA5, 1'b1, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b1, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h3C, 1'b1, 1'b0, '0},
    '{8'h77, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0}
  };

  lzb_in_if  in_ch ();
  lzb_out_if out_ch ();

  lz_backref_stream_decompressor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic void record_byte(logic [7:0] b);
    hist_mem[wr_pos] = b;
    wr_pos = wr_pos + WIN_AW'(1);
    produced = (produced + 1) & 32'hFFFFFF;
  endfunction

  function automatic void close_literals();
    if (stop_seen) begin
      stat = ST_DONE;
      dph = DP_HALT;
    end else if (copy_left == 0) begin
      dph = DP_CMD;
    end else if (copy_dist + 1 > produced) begin
      stat = ST_BADREF;
      dph = DP_HALT;
    end else begin
      dph = DP_COPY;
    end
  endfunction

  function automatic res_t decompress_step(logic [7:0] b, logic v);
    res_t              r;
    logic [WIN_AW-1:0] rd;
    int unsigned       need, n, c0, b1, b2, b3;
    r = '0;
    if (dph == DP_COPY) begin
      if (produced >= decl_size) begin
        stat = ST_OVERFLOW;
        dph = DP_HALT;
      end else begin
        rd = WIN_AW'(wr_pos - copy_dist - 1);
        r.out_byte = hist_mem[rd];
        r.out_valid = 1'b1;
        record_byte(hist_mem[rd]);
        copy_left--;
        if (copy_left == 0) dph = DP_CMD;
      end
    end else if (dph != DP_HALT && v) begin
      case (dph)
        DP_SIG: begin
          r.byte_taken = 1'b1;
          if (hdr_cnt == 0) begin
            packed_size_flag = b[0];
            hdr_cnt = 1;
          end else begin
            hdr_cnt = 0;
            if (packed_size_flag) dph = DP_SKIP;
            else dph = DP_SIZE;
          end
        end
        DP_SKIP: begin
          r.byte_taken = 1'b1;
          hdr_cnt++;
          if (hdr_cnt >= 3) begin
            hdr_cnt = 0;
            dph = DP_SIZE;
          end
        end
        DP_SIZE: begin
          r.byte_taken = 1'b1;
          decl_size = ((decl_size << 8) | 32'(b)) & 32'hFFFFFF;
          hdr_cnt++;
          if (hdr_cnt >= 3) begin
            hdr_cnt = 0;
            dph = DP_CMD;
          end
        end
        DP_CMD: begin
          r.byte_taken = 1'b1;
          cmd_buf[cmd_idx] = b;
          c0 = {24'd0, cmd_buf[0]};
          if (!c0[7]) need = 2;
          else if (!c0[6]) need = 3;
          else if (!c0[5]) need = 4;
          else need = 1;
          if (cmd_idx + 1 >= need) begin
            cmd_idx = 0;
            b1 = {24'd0, cmd_buf[1]};
            b2 = {24'd0, cmd_buf[2]};
            b3 = {24'd0, cmd_buf[3]};
            stop_seen = 1'b0;
            copy_left = 0;
            if (need == 2) begin
              lits_left = c0 & 32'h03;
              copy_dist = ((c0 & 32'h60) << 3) + b1;
              copy_left = ((c0 >> 2) & 32'h07) + 3;
            end else if (need == 3) begin
              lits_left = b1 >> 6;
              copy_dist = ((b1 & 32'h3F) << 8) + b2;
              copy_left = (c0 & 32'h3F) + 4;
            end else if (need == 4) begin
              lits_left = c0 & 32'h03;
              copy_dist = ((c0 & 32'h10) << 12) + (b1 << 8) + b2;
              copy_left = ((c0 & 32'h0C) << 6) + b3 + 5;
            end else begin
              n = (c0 & 32'h1F) * 4 + 4;
              if (n <= 32'h70) begin
                lits_left = n;
              end else begin
                lits_left = c0 & 32'h03;
                stop_seen = 1'b1;
              end
            end
            if (lits_left > 0) dph = DP_LIT;
            else close_literals();
          end else begin
            cmd_idx++;
          end
        end
        DP_LIT: begin
          if (produced >= decl_size) begin
            stat = ST_OVERFLOW;
            dph = DP_HALT;
          end else begin
            r.byte_taken = 1'b1;
            r.out_byte = b;
            r.out_valid = 1'b1;
            record_byte(b);
            lits_left--;
            if (lits_left == 0) close_literals();
          end
        end
        default: ;
      endcase
    end
    r.status = stat;
    r.declared_size = decl_size[23:0];
    return r;
  endfunction

  function automatic void push_literals(int unsigned cnt);
    repeat (cnt) packed_stream.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned pick_back_dist(int unsigned maxd);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, min_u(maxd, 4));
    return $urandom_range(0, maxd);
  endfunction

  function automatic void emit_copy_cmd(cmd_kind_e kind, int unsigned lits,
                                        int unsigned bd, int unsigned len);
    case (kind)
      CK_TWO: begin
        packed_stream.push_back(8'(((bd >> 8) << 5) | ((len - 3) << 2) | lits));
        packed_stream.push_back(8'(bd));
      end
      CK_THREE: begin
        packed_stream.push_back(8'(8'h80 | (len - 4)));
        packed_stream.push_back(8'((lits << 6) | (bd >> 8)));
        packed_stream.push_back(8'(bd));
      end
      default: begin
        packed_stream.push_back(8'(8'hC0 | ((bd >> 16) << 4) | (((len - 5) >> 8) << 2) | lits));
        packed_stream.push_back(8'(bd >> 8));
        packed_stream.push_back(8'(bd));
        packed_stream.push_back(8'(len - 5));
      end
    endcase
    push_literals(lits);
  endfunction

  task automatic compose_stream();
    int unsigned room, lits, bd, len, hi, n, k;
    cmd_kind_e   kind;
    end_kind_e   tail;
    plan_out = produced;
    while (DECL_SIZE - plan_out > 40) begin
      room = DECL_SIZE - plan_out;
      kind = cmd_kind_e'($urandom_range(0, 3));
      if (kind == CK_RUN) begin
        hi = ($urandom_range(0, 3) == 0) ? min_u(28, room / 4) : min_u(8, room / 4);
        n = 4 * $urandom_range(1, hi);
        packed_stream.push_back(8'(8'hE0 | (n / 4 - 1)));
        push_literals(n);
        plan_out += n;
      end else begin
        lits = $urandom_range(0, 3);
        bd = pick_back_dist(min_u(DIST_CAP[kind], plan_out + lits - 1));
        hi = LEN_HI[kind];
        if ($urandom_range(0, 7) != 0) hi = min_u(hi, 24);
        len = $urandom_range(LEN_LO[kind], min_u(hi, room - lits));
        emit_copy_cmd(kind, lits, bd, len);
        plan_out += lits + len;
      end
    end
    room = DECL_SIZE - plan_out;
    tail = end_kind_e'($urandom_range(0, 3));
    case (tail)
      END_STOP: begin
        k = $urandom_range(0, min_u(3, room));
        packed_stream.push_back(8'(8'hFC | k));
        push_literals(k);
      end
      END_BADREF: begin
        kind = cmd_kind_e'($urandom_range(0, 2));
        lits = $urandom_range(0, min_u(3, room));
        bd = $urandom_range(plan_out + lits, DIST_CAP[kind]);
        emit_copy_cmd(kind, lits, bd, $urandom_range(LEN_LO[kind], LEN_HI[kind]));
      end
      END_OVER_LIT: begin
        n = (room / 4 + 1) * 4;
        packed_stream.push_back(8'(8'hE0 | (n / 4 - 1)));
        push_literals(n);
      end
      default: begin
        emit_copy_cmd(CK_THREE, 0, pick_back_dist(min_u(DIST_CAP[CK_THREE], plan_out - 1)),
                      $urandom_range(room + LEN_LO[CK_THREE], LEN_HI[CK_THREE]));
      end
    endcase
  endtask

  task automatic offer(logic [7:0] b, logic v);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 30) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_valid <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  initial begin
    res_t       got;
    logic [7:0] b;
    logic       v;
    int         n_steps;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_valid <= 1'b0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].b, dir_rows[i].v);
      got = decompress_step(dir_rows[i].b, dir_rows[i].v);
      predicted_steps.push_back(dir_rows[i].known ? dir_rows[i].want : got);
    end

    compose_stream();
    n_steps = 0;
    while (dph != DP_HALT) begin
      no_idle <= (n_steps >= 500 && n_steps < 700);
      v = ($urandom_range(0, 19) != 0);
      if (v && packed_stream.size() > 0) b = packed_stream[0];
      else b = 8'($urandom_range(0, 255));
      offer(b, v);
      got = decompress_step(b, v);
      predicted_steps.push_back(got);
      if (got.byte_taken) void'(packed_stream.pop_front());
      n_steps++;
    end
    no_idle <= 1'b0;

    // hold the halted state under further traffic
    repeat (8) begin
      b = 8'($urandom_range(0, 255));
      v = 1'($urandom_range(0, 1));
      offer(b, v);
      predicted_steps.push_back(decompress_step(b, v));
    end
    in_ch.valid <= 1'b0;

    while (predicted_steps.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    res_t want;
    int   results_seen;
    int   hold_left;
    bit   held_once;
    results_seen = 0;
    hold_left = 0;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (predicted_steps.size() == 0) begin
          log_mismatch($sformatf("unexpected transaction: byte %h valid %b taken %b status %0d size %h",
                                 out_ch.out_byte, out_ch.out_valid, out_ch.byte_taken,
                                 out_ch.status, out_ch.declared_size));
        end else begin
          want = predicted_steps.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.out_valid !== want.out_valid ||
              out_ch.byte_taken !== want.byte_taken || out_ch.status !== want.status ||
              out_ch.declared_size !== want.declared_size) begin
            log_mismatch($sformatf({"transaction %0d: expected byte %h valid %b taken %b ",
                                    "status %0d size %h, got byte %h valid %b taken %b ",
                                    "status %0d size %h"},
                                   results_seen, want.out_byte, want.out_valid,
                                   want.byte_taken, want.status, want.declared_size,
                                   out_ch.out_byte, out_ch.out_valid, out_ch.byte_taken,
                                   out_ch.status, out_ch.declared_size));
          end
        end
        results_seen++;
      end
      // stall the result side long enough to back up the input
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!held_once && results_seen >= 300) begin
        out_ch.ready <= 1'b0;
        hold_left = 199;
        held_once = 1'b1;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
      end
    end
  end

endmodule
